// ===== rtl/mie_pkg.sv =====
package mie_pkg;

  localparam int unsigned MEM_WORDS_DEF = 4096;
  localparam int unsigned GPR_DEPTH     = 32;
  localparam int unsigned DIV_STEPS     = 32;

  localparam logic [31:0] TEXT_BASE_RST = 32'd0;
  localparam logic [31:0] DATA_BASE_RST = 32'd8192;
  localparam logic [31:0] STACK_TOP_RST = 32'd16380;
  localparam logic [31:0] END_PC        = 32'h0000_FFFF;

  localparam logic [1:0] CFG_TEXT_BASE = 2'd0;
  localparam logic [1:0] CFG_DATA_BASE = 2'd1;
  localparam logic [1:0] CFG_STACK_TOP = 2'd2;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_ALIGN    = 3'd1;
  localparam logic [2:0] FLT_OVERFLOW = 3'd2;
  localparam logic [2:0] FLT_DIVZERO  = 3'd3;
  localparam logic [2:0] FLT_UNKNOWN  = 3'd4;
  localparam logic [2:0] FLT_BOUNDS   = 3'd5;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  localparam logic [31:0] SYS_SBRK  = 32'd9;
  localparam logic [31:0] SYS_EXIT  = 32'd10;
  localparam logic [31:0] SYS_EXIT2 = 32'd17;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_V0   = 5'd2;
  localparam logic [4:0] REG_A0   = 5'd4;
  localparam logic [4:0] REG_K0   = 5'd26;
  localparam logic [4:0] REG_SP   = 5'd29;
  localparam logic [4:0] REG_RA   = 5'd31;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_MEM, ST_MUL, ST_DIV, ST_SYS_READ, ST_SYS_EXEC, ST_SYS_K0
  } state_e;

  typedef enum logic [2:0] {
    PH_EXEC, PH_MEM, PH_MUL, PH_DIV, PH_SYS, PH_SYS_K0
  } phase_e;

  typedef enum logic [1:0] {RD_INSTR, RD_SYS, RD_K0} rd_sel_e;

  typedef enum logic [2:0] {CL_SIMPLE, CL_MEM, CL_MUL, CL_DIV, CL_SYS} cls_e;

  typedef struct packed {
    phase_e  phase;
    logic    commit;
    logic    accept;
    rd_sel_e rd_sel;
    logic    rf_re;
    logic    mem_re;
    logic    mul_load;
    logic    div_start;
    logic    div_step;
    logic    code_ld;
    logic    clr_en;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic div_done;
    logic is_sbrk;
    logic clr_done;
  } status_t;

  function automatic logic [31:0] gpr_reset_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      REG_SP:  v = STACK_TOP_RST;
      REG_RA:  v = END_PC;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mips_integer_instruction_executor.sv =====
// Executes one MIPS-I integer instruction per input transfer, without delay slots.
// The input channel carries the instruction word; the output channel returns one
// result per instruction: next pc, sticky fault code and pc, register writeback,
// halt flag, exit status and any host service request.
// The configuration channel sets text base, data base and stack top; the user is
// to write it only while idle, which the block itself does not enforce. ALU, branch
// and jump instructions need only the register file read; loads, stores and
// multiplies then read data memory or the product register; divides by a nonzero
// divisor produce one quotient bit per cycle in the shared divider; syscalls add
// reads of v0, a0 and k0, and a second write for sbrk. One instruction is in flight
// at a time. After reset the data memory is cleared one word per cycle, during which
// no instruction is taken; configuration writes are taken throughout.
// A result waits in the output register while the receiver stalls; the next
// instruction is taken meanwhile but holds its result until the register drains.
module mips_integer_instruction_executor
  import mie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic [2:0]  fault_o,
  output logic [31:0] fault_pc_o,
  output logic        writeback_valid_o,
  output logic [4:0]  writeback_reg_o,
  output logic [31:0] writeback_value_o,
  output logic        halted_o,
  output logic [31:0] exit_status_o,
  output logic        service_request_o,
  output logic [31:0] service_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mie_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  mie_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .instruction_i,
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .next_pc_o, .fault_o, .fault_pc_o, .writeback_valid_o, .writeback_reg_o,
    .writeback_value_o, .halted_o, .exit_status_o, .service_request_o, .service_code_o
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an instruction is in flight");

  a_halt_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (halted_o == (next_pc_o == END_PC)))
    else $error("halt flag disagrees with next pc");

  a_wb_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_valid_o |-> fault_o == FLT_NONE && writeback_reg_o != REG_ZERO)
    else $error("writeback reported under a fault or to register zero");

endmodule

// ===== rtl/mie_ram.sv =====
module mie_ram
  import mie_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = MEM_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mie_ctrl.sv =====
module mie_ctrl
  import mie_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (status_i.cls)
          CL_MEM:  state_d = ST_MEM;
          CL_MUL:  state_d = ST_MUL;
          CL_DIV:  state_d = ST_DIV;
          CL_SYS:  state_d = ST_SYS_READ;
          default: if (slot_free) state_d = ST_IDLE;
        endcase
      end
      ST_MEM, ST_MUL: begin
        if (slot_free) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (status_i.div_done && slot_free) state_d = ST_IDLE;
      end
      ST_SYS_READ: state_d = ST_SYS_EXEC;
      ST_SYS_EXEC: begin
        if (slot_free) state_d = status_i.is_sbrk ? ST_SYS_K0 : ST_IDLE;
      end
      ST_SYS_K0: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.phase  = PH_EXEC;
    cmd_o.rd_sel = RD_INSTR;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.rf_re  = in_valid_i;
      end
      ST_EXEC: begin
        case (status_i.cls)
          CL_MEM:  cmd_o.mem_re = 1'b1;
          CL_MUL:  cmd_o.mul_load = 1'b1;
          CL_DIV:  cmd_o.div_start = 1'b1;
          CL_SYS: begin
            cmd_o.rd_sel = RD_SYS;
            cmd_o.rf_re  = 1'b1;
          end
          default: cmd_o.commit = slot_free;
        endcase
      end
      ST_MEM: begin
        cmd_o.phase  = PH_MEM;
        cmd_o.commit = slot_free;
      end
      ST_MUL: begin
        cmd_o.phase  = PH_MUL;
        cmd_o.commit = slot_free;
      end
      ST_DIV: begin
        cmd_o.phase    = PH_DIV;
        cmd_o.div_step = !status_i.div_done;
        cmd_o.commit   = status_i.div_done && slot_free;
      end
      ST_SYS_READ: begin
        cmd_o.phase   = PH_SYS;
        cmd_o.code_ld = 1'b1;
        cmd_o.rd_sel  = RD_K0;
        cmd_o.rf_re   = 1'b1;
      end
      ST_SYS_EXEC: begin
        cmd_o.phase  = PH_SYS;
        cmd_o.commit = slot_free;
      end
      ST_SYS_K0: begin
        cmd_o.phase  = PH_SYS_K0;
        cmd_o.commit = 1'b1;
      end
      default: cmd_o.phase = PH_EXEC;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit && cmd_o.phase != PH_SYS_K0) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/mie_dp.sv =====
module mie_dp
  import mie_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [31:0] instruction_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic [31:0] next_pc_o,
  output logic [2:0]  fault_o,
  output logic [31:0] fault_pc_o,
  output logic        writeback_valid_o,
  output logic [4:0]  writeback_reg_o,
  output logic [31:0] writeback_value_o,
  output logic        halted_o,
  output logic [31:0] exit_status_o,
  output logic        service_request_o,
  output logic [31:0] service_code_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned GW = $clog2(GPR_DEPTH);

  logic [31:0] text_base_q, data_base_q, stack_top_q;
  logic [31:0] instr_q, pc_q, hi_q, lo_q, fault_pc_q, exit_q, code_q;
  logic [2:0]  fault_q;
  logic [GPR_DEPTH-1:0] gvld_q;
  logic [GW-1:0] ra_q, rb_q, ra_d, rb_d;
  logic [31:0] ram_a, ram_b, a, b;
  logic [63:0] prod_q;
  logic [32:0] rem_q;
  logic [31:0] quo_q, dvs_q;
  logic [5:0]  dcnt_q;
  logic [AW-1:0] clr_q;

  logic [31:0] next_pc_q, fault_pc_oq, wb_value_q, exit_oq, svc_code_q;
  logic [2:0]  fault_oq;
  logic        wb_valid_q, halted_q, svc_q;
  logic [4:0]  wb_reg_q;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] imm, simm, ea, wa, pc4, mem_rdata;

  assign op   = instr_q[31:26];
  assign rt   = instr_q[20:16];
  assign rd   = instr_q[15:11];
  assign sh   = instr_q[10:6];
  assign fn   = instr_q[5:0];
  assign imm  = {16'd0, instr_q[15:0]};
  assign simm = {{16{instr_q[15]}}, instr_q[15:0]};
  assign ea   = a + simm;
  assign wa   = {ea[31:2], 2'b00};
  assign pc4  = pc_q + 32'd4;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SYS: begin
        ra_d = GW'(REG_V0);
        rb_d = GW'(REG_A0);
      end
      RD_K0: begin
        ra_d = GW'(REG_K0);
        rb_d = GW'(REG_A0);
      end
      default: begin
        ra_d = instruction_i[25:21];
        rb_d = instruction_i[20:16];
      end
    endcase
  end

  logic        rf_we;
  logic [4:0]  wr_reg;
  logic [31:0] wr_val;

  mie_ram #(.WIDTH(32), .DEPTH(GPR_DEPTH)) u_gpr_a (
    .clk_i, .we_i(rf_we), .waddr_i(wr_reg), .wdata_i(wr_val),
    .re_i(cmd_i.rf_re), .raddr_i(ra_d), .rdata_o(ram_a)
  );

  mie_ram #(.WIDTH(32), .DEPTH(GPR_DEPTH)) u_gpr_b (
    .clk_i, .we_i(rf_we), .waddr_i(wr_reg), .wdata_i(wr_val),
    .re_i(cmd_i.rf_re), .raddr_i(rb_d), .rdata_o(ram_b)
  );

  assign a = (ra_q == REG_ZERO) ? 32'd0 : (gvld_q[ra_q] ? ram_a : gpr_reset_val(ra_q));
  assign b = (rb_q == REG_ZERO) ? 32'd0 : (gvld_q[rb_q] ? ram_b : gpr_reset_val(rb_q));

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata, st_data;
  logic          st_en;

  mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .re_i(cmd_i.mem_re), .raddr_i(ea[AW+1:2]), .rdata_o(mem_rdata)
  );

  logic ld_legal, st_legal;
  assign ld_legal = (wa >= text_base_q) && (wa <= stack_top_q) &&
                    (wa[31:2] < 30'(MEM_WORDS));
  assign st_legal = ld_legal && (wa >= data_base_q);

  logic [31:0] s_add, s_sub, s_addi, inc;
  logic        ov_add, ov_sub, ov_addi;
  assign s_add   = a + b;
  assign s_sub   = a - b;
  assign s_addi  = a + simm;
  assign ov_add  = !(a[31] ^ b[31]) && (s_add[31] ^ a[31]);
  assign ov_sub  = (a[31] ^ b[31]) && (s_sub[31] ^ a[31]);
  assign ov_addi = !(a[31] ^ simm[31]) && (s_addi[31] ^ a[31]);
  assign inc     = (b != 32'd0 && !b[31]) ? ((b + 32'd3) & ~32'd3) : b;

  logic        dsigned;
  logic [31:0] ma, mb, dq, dr;
  logic [32:0] trial;
  assign dsigned = (fn == FN_DIV);
  assign ma      = (dsigned && a[31]) ? 32'd0 - a : a;
  assign mb      = (dsigned && b[31]) ? 32'd0 - b : b;
  assign trial   = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};
  assign dq      = (dsigned && (a[31] ^ b[31])) ? 32'd0 - quo_q : quo_q;
  assign dr      = (dsigned && a[31]) ? 32'd0 - rem_q[31:0] : rem_q[31:0];

  logic [65:0] prod_d;
  logic        msgn;
  assign msgn   = (fn == FN_MULT);
  assign prod_d = $signed({msgn & a[31], a}) * $signed({msgn & b[31], b});

  always_comb begin
    status_o.cls = CL_SIMPLE;
    if (op == OP_SPECIAL) begin
      case (fn)
        FN_SYSCALL:        status_o.cls = CL_SYS;
        FN_MULT, FN_MULTU: status_o.cls = CL_MUL;
        FN_DIV, FN_DIVU:   status_o.cls = (b == 32'd0) ? CL_SIMPLE : CL_DIV;
        default:           status_o.cls = CL_SIMPLE;
      endcase
    end else if (op inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW}) begin
      status_o.cls = CL_MEM;
    end
  end

  assign status_o.div_done = (dcnt_q == 6'(DIV_STEPS));
  assign status_o.is_sbrk  = (code_q == SYS_SBRK);
  assign status_o.clr_done = (clr_q == AW'(MEM_WORDS - 1));

  logic [31:0] npc, hi_n, lo_n, exit_n, svc_code;
  logic [2:0]  fcode;
  logic        wr_en, report, hi_en, lo_en, exit_en, svc, taken;

  always_comb begin
    npc      = pc4;
    fcode    = FLT_NONE;
    wr_en    = 1'b0;
    wr_reg   = rd;
    wr_val   = 32'd0;
    report   = 1'b1;
    hi_en    = 1'b0;
    lo_en    = 1'b0;
    hi_n     = 32'd0;
    lo_n     = 32'd0;
    st_en    = 1'b0;
    st_data  = mem_rdata;
    exit_en  = 1'b0;
    exit_n   = 32'd0;
    svc      = 1'b0;
    svc_code = 32'd0;
    taken    = 1'b0;
    case (cmd_i.phase)
      PH_EXEC: begin
        if (op == OP_SPECIAL) begin
          wr_en = 1'b1;
          case (fn)
            FN_SLL:  wr_val = b << sh;
            FN_SRL:  wr_val = b >> sh;
            FN_SRA:  wr_val = $unsigned($signed(b) >>> sh);
            FN_SLLV: wr_val = b << a[4:0];
            FN_SRLV: wr_val = b >> a[4:0];
            FN_SRAV: wr_val = $unsigned($signed(b) >>> a[4:0]);
            FN_JR: begin
              wr_en = 1'b0;
              npc   = a;
            end
            FN_JALR: begin
              npc    = a;
              wr_val = pc4;
            end
            FN_MFHI: wr_val = hi_q;
            FN_MFLO: wr_val = lo_q;
            FN_MTHI: begin
              wr_en = 1'b0;
              hi_en = 1'b1;
              hi_n  = a;
            end
            FN_MTLO: begin
              wr_en = 1'b0;
              lo_en = 1'b1;
              lo_n  = a;
            end
            FN_DIV, FN_DIVU: begin
              wr_en = 1'b0;
              fcode = FLT_DIVZERO;
            end
            FN_ADD: begin
              wr_val = s_add;
              if (ov_add) fcode = FLT_OVERFLOW;
            end
            FN_ADDU: wr_val = s_add;
            FN_SUB: begin
              wr_val = s_sub;
              if (ov_sub) fcode = FLT_OVERFLOW;
            end
            FN_SUBU: wr_val = s_sub;
            FN_AND:  wr_val = a & b;
            FN_OR:   wr_val = a | b;
            FN_XOR:  wr_val = a ^ b;
            FN_NOR:  wr_val = ~(a | b);
            FN_SLT:  wr_val = {31'd0, $signed(a) < $signed(b)};
            FN_SLTU: wr_val = {31'd0, a < b};
            default: begin
              wr_en = 1'b0;
              fcode = FLT_UNKNOWN;
              npc   = pc_q;
            end
          endcase
        end else if (op == OP_J || op == OP_JAL) begin
          wr_en  = (op == OP_JAL);
          wr_reg = REG_RA;
          wr_val = pc4;
          npc    = {4'd0, instr_q[25:0], 2'b00};
        end else if (op inside {[OP_REGIMM:OP_BGTZ]}) begin
          if (op == OP_REGIMM && rt > 5'd1) begin
            fcode = FLT_UNKNOWN;
            npc   = pc_q;
          end else begin
            case (op)
              OP_REGIMM: taken = (rt == 5'd1) ? !a[31] : a[31];
              OP_BEQ:    taken = (a == b);
              OP_BNE:    taken = (a != b);
              OP_BLEZ:   taken = a[31] || (a == 32'd0);
              default:   taken = !a[31] && (a != 32'd0);
            endcase
            if (taken) npc = pc4 + {simm[29:0], 2'b00};
          end
        end else begin
          wr_en  = 1'b1;
          wr_reg = rt;
          case (op)
            OP_ADDI: begin
              wr_val = s_addi;
              if (ov_addi) fcode = FLT_OVERFLOW;
            end
            OP_ADDIU: wr_val = s_addi;
            OP_SLTI:  wr_val = {31'd0, $signed(a) < $signed(simm)};
            OP_SLTIU: wr_val = {31'd0, a < simm};
            OP_ANDI:  wr_val = a & imm;
            OP_ORI:   wr_val = a | imm;
            OP_XORI:  wr_val = a ^ imm;
            OP_LUI:   wr_val = {instr_q[15:0], 16'd0};
            default: begin
              wr_en = 1'b0;
              fcode = FLT_UNKNOWN;
              npc   = pc_q;
            end
          endcase
        end
      end
      PH_MEM: begin
        wr_reg = rt;
        case (op)
          OP_LB, OP_LBU: begin
            case (ea[1:0])
              2'd0:    wr_val = {24'd0, mem_rdata[31:24]};
              2'd1:    wr_val = {24'd0, mem_rdata[23:16]};
              2'd2:    wr_val = {24'd0, mem_rdata[15:8]};
              default: wr_val = {24'd0, mem_rdata[7:0]};
            endcase
            if (op == OP_LB) wr_val = {{24{wr_val[7]}}, wr_val[7:0]};
            if (!ld_legal) fcode = FLT_BOUNDS;
            else wr_en = 1'b1;
          end
          OP_LH, OP_LHU: begin
            wr_val = ea[1] ? {16'd0, mem_rdata[15:0]} : {16'd0, mem_rdata[31:16]};
            if (op == OP_LH) wr_val = {{16{wr_val[15]}}, wr_val[15:0]};
            if (ea[0]) fcode = FLT_ALIGN;
            else if (!ld_legal) fcode = FLT_BOUNDS;
            else wr_en = 1'b1;
          end
          OP_LW: begin
            wr_val = mem_rdata;
            if (ea[1:0] != 2'd0) fcode = FLT_ALIGN;
            else if (!ld_legal) fcode = FLT_BOUNDS;
            else wr_en = 1'b1;
          end
          OP_SB: begin
            case (ea[1:0])
              2'd0:    st_data[31:24] = b[7:0];
              2'd1:    st_data[23:16] = b[7:0];
              2'd2:    st_data[15:8]  = b[7:0];
              default: st_data[7:0]   = b[7:0];
            endcase
            if (!st_legal) fcode = FLT_BOUNDS;
            else st_en = 1'b1;
          end
          OP_SH: begin
            if (ea[1]) st_data[15:0] = b[15:0];
            else st_data[31:16] = b[15:0];
            if (ea[0]) fcode = FLT_ALIGN;
            else if (!st_legal) fcode = FLT_BOUNDS;
            else st_en = 1'b1;
          end
          default: begin
            st_data = b;
            if (ea[1:0] != 2'd0) fcode = FLT_ALIGN;
            else if (!((ea >= data_base_q) && (ea <= stack_top_q) &&
                       (ea[31:2] < 30'(MEM_WORDS)))) fcode = FLT_BOUNDS;
            else st_en = 1'b1;
          end
        endcase
      end
      PH_MUL: begin
        hi_en = 1'b1;
        lo_en = 1'b1;
        hi_n  = prod_q[63:32];
        lo_n  = prod_q[31:0];
      end
      PH_DIV: begin
        hi_en = 1'b1;
        lo_en = 1'b1;
        hi_n  = dr;
        lo_n  = dq;
      end
      PH_SYS: begin
        case (code_q)
          SYS_SBRK: begin
            wr_en  = 1'b1;
            wr_reg = REG_V0;
            wr_val = a;
          end
          SYS_EXIT: begin
            npc     = END_PC;
            exit_en = 1'b1;
          end
          SYS_EXIT2: begin
            npc     = END_PC;
            exit_en = 1'b1;
            exit_n  = b;
          end
          default: begin
            svc      = 1'b1;
            svc_code = code_q;
          end
        endcase
      end
      PH_SYS_K0: begin
        wr_en  = 1'b1;
        wr_reg = REG_K0;
        wr_val = a + inc;
        report = 1'b0;
      end
      default: npc = pc4;
    endcase
  end

  logic       ok, out_load;
  logic [2:0] fault_n;
  assign ok       = (fcode == FLT_NONE) && (fault_q == FLT_NONE);
  assign rf_we    = cmd_i.commit && wr_en && ok && (wr_reg != REG_ZERO);
  assign out_load = cmd_i.commit && (cmd_i.phase != PH_SYS_K0);
  assign fault_n  = (fault_q != FLT_NONE) ? fault_q : fcode;

  always_comb begin
    mem_we    = cmd_i.commit && st_en && ok;
    mem_waddr = wa[AW+1:2];
    mem_wdata = st_data;
    if (cmd_i.clr_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q <= TEXT_BASE_RST;
      data_base_q <= DATA_BASE_RST;
      stack_top_q <= STACK_TOP_RST;
      pc_q        <= TEXT_BASE_RST;
      hi_q        <= 32'd0;
      lo_q        <= 32'd0;
      fault_q     <= FLT_NONE;
      fault_pc_q  <= 32'd0;
      exit_q      <= 32'd0;
      gvld_q      <= '0;
      clr_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TEXT_BASE: text_base_q <= cfg_data_i;
          CFG_DATA_BASE: data_base_q <= cfg_data_i;
          CFG_STACK_TOP: stack_top_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);
      if (cmd_i.div_start) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + 6'd1;
      if (rf_we) gvld_q[wr_reg] <= 1'b1;
      if (cmd_i.commit && ok && hi_en) hi_q <= hi_n;
      if (cmd_i.commit && ok && lo_en) lo_q <= lo_n;
      if (out_load) begin
        pc_q    <= npc;
        fault_q <= fault_n;
        if (fault_q == FLT_NONE && fcode != FLT_NONE) fault_pc_q <= pc_q;
        if (exit_en) exit_q <= exit_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) instr_q <= instruction_i;
    if (cmd_i.rf_re) begin
      ra_q <= ra_d;
      rb_q <= rb_d;
    end
    if (cmd_i.code_ld) code_q <= a;
    if (cmd_i.mul_load) prod_q <= prod_d[63:0];
    if (cmd_i.div_start) begin
      rem_q <= 33'd0;
      quo_q <= ma;
      dvs_q <= mb;
    end else if (cmd_i.div_step) begin
      if (!trial[32]) begin
        rem_q <= trial;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (out_load) begin
      next_pc_q   <= npc;
      fault_oq    <= fault_n;
      fault_pc_oq <= (fault_q == FLT_NONE && fcode != FLT_NONE) ? pc_q : fault_pc_q;
      wb_valid_q  <= rf_we && report;
      wb_reg_q    <= (rf_we && report) ? wr_reg : 5'd0;
      wb_value_q  <= (rf_we && report) ? wr_val : 32'd0;
      halted_q    <= (npc == END_PC);
      exit_oq     <= exit_en ? exit_n : exit_q;
      svc_q       <= svc;
      svc_code_q  <= svc_code;
    end
  end

  assign next_pc_o         = next_pc_q;
  assign fault_o           = fault_oq;
  assign fault_pc_o        = fault_pc_oq;
  assign writeback_valid_o = wb_valid_q;
  assign writeback_reg_o   = wb_reg_q;
  assign writeback_value_o = wb_value_q;
  assign halted_o          = halted_q;
  assign exit_status_o     = exit_oq;
  assign service_request_o = svc_q;
  assign service_code_o    = svc_code_q;

endmodule
